FILE: rtl/multi_key_doc_comparator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-key document comparator checks.
// Each macro expects clk and rst to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef MULTI_KEY_DOC_COMPARATOR_UNIT_ASSERT_SVH
`define MULTI_KEY_DOC_COMPARATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MKDC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("comparator check failed in the same cycle");

// Next-cycle implication, checked outside reset.
`define MKDC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("comparator check failed in the next cycle");

`endif

FILE: rtl/mkdc_pkg.sv
// ----------------------------------------------------------------------------
// mkdc_pkg
// Shared widths, register indexes and control structs of the comparator.
// ----------------------------------------------------------------------------
package mkdc_pkg;

  // Field widths fixed by the interface.
  localparam int DOC_W     = 10;
  localparam int VAL_W     = 32;
  localparam int KEY_IDX_W = 3;
  localparam int KCNT_W    = 4;
  localparam int RMASK_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MASK = 1'b1;

  // Item mode codes.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPARE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic reduce;    // first step of the document slot reduction
    logic fix;       // finish the slot reduction
    logic store;     // write the sort table entry of a load
    logic first;     // read key 0 of both documents
    logic step;      // read the next key while checking the current one
    logic emit_key;  // deliver the answer decided by the current key
    logic emit_tie;  // deliver the score or document tie-break answer
  } mkdc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_compare;   // the held item is a compare
    logic no_keys;      // no sort keys are in use
    logic key_differs;  // the two values of the current key differ
    logic last_key;     // the current key is the last key in use
  } mkdc_stat_t;

endpackage

FILE: rtl/multi_key_doc_comparator_unit.sv
// ----------------------------------------------------------------------------
// multi_key_doc_comparator_unit
// Orders two search results by a list of per-key sort tables, then by score
// and document number.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. A load
//   item (mode 0) writes sort_value into key key_index's table at doc_a and
//   gives no result. A compare item (mode 1) answers whether doc_a collates
//   before doc_b; the answer appears on a_first with done high for one cycle.
//   key_count and reverse_mask are written through cfg_write, cfg_index and
//   cfg_data while the block is idle; a write takes effect at once.
// Sequence:
//   A load steps through slot reduction and the table write with busy high.
//   A compare walks keys one per cycle, each step being one read of both
//   documents from the sort table, until a key differs; after the last key
//   in use (key_count, at most MAX_KEYS) it falls back to the score and
//   document tie-break, used at once when no key is in use. A new item
//   may be taken in the cycle that done is high.
// Reset:
//   rst clears the sequencer and both configuration registers. The sort
//   table is not cleared; entries must be loaded before they are compared.
//   The receiver cannot stall: every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module multi_key_doc_comparator_unit #(
  parameter int MAX_KEYS  = 8,
  parameter int DOC_COUNT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_write,
  input  logic [mkdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mkdc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              mode,
  input  logic [mkdc_pkg::KEY_IDX_W-1:0]    key_index,
  input  logic [mkdc_pkg::DOC_W-1:0]        doc_a,
  input  logic [mkdc_pkg::DOC_W-1:0]        doc_b,
  input  logic signed [mkdc_pkg::VAL_W-1:0] sort_value,
  input  logic signed [mkdc_pkg::VAL_W-1:0] score_a,
  input  logic signed [mkdc_pkg::VAL_W-1:0] score_b,
  output logic                              done,
  output logic                              a_first
);
  import mkdc_pkg::*;

  mkdc_cmd_t  cmd;
  mkdc_stat_t stat;

  // Sequencer.
  mkdc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Storage and comparison.
  mkdc_datapath #(
    .MAX_KEYS  (MAX_KEYS),
    .DOC_COUNT (DOC_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .key_index  (key_index),
    .doc_a      (doc_a),
    .doc_b      (doc_b),
    .sort_value (sort_value),
    .score_a    (score_a),
    .score_b    (score_b),
    .done       (done),
    .a_first    (a_first)
  );

endmodule

FILE: rtl/mkdc_ctrl.sv
// ----------------------------------------------------------------------------
// mkdc_ctrl
// Sequencer of the comparator: steps each item through slot reduction,
// then a table write, the key walk with its tie-break, or the tie-break alone.
// ----------------------------------------------------------------------------
module mkdc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mkdc_pkg::mkdc_stat_t stat,
  output mkdc_pkg::mkdc_cmd_t  cmd,
  output logic               busy
);
  import mkdc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_FIX,
    S_WRITE,
    S_FIRST,
    S_WALK
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands for the current state.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.reduce = 1'b1;
        state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix = 1'b1;
        if (!stat.is_compare) begin
          state_next = S_WRITE;
        end else if (stat.no_keys) begin
          cmd.emit_tie = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_FIRST;
        end
      end
      S_WRITE: begin
        cmd.store  = 1'b1;
        state_next = S_IDLE;
      end
      S_FIRST: begin
        cmd.first  = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (stat.key_differs) begin
          cmd.emit_key = 1'b1;
          state_next   = S_IDLE;
        end else if (stat.last_key) begin
          cmd.emit_tie = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and registered busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

FILE: rtl/mkdc_datapath.sv
// ----------------------------------------------------------------------------
// mkdc_datapath
// Item registers, configuration registers, document slot reduction, the
// dual-read sort table and the key and tie-break comparisons.
// ----------------------------------------------------------------------------
module mkdc_datapath #(
  parameter int MAX_KEYS  = 8,
  parameter int DOC_COUNT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mkdc_pkg::mkdc_cmd_t                  cmd,
  output mkdc_pkg::mkdc_stat_t                 stat,
  input  logic                                 cfg_write,
  input  logic [mkdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mkdc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 mode,
  input  logic [mkdc_pkg::KEY_IDX_W-1:0]       key_index,
  input  logic [mkdc_pkg::DOC_W-1:0]           doc_a,
  input  logic [mkdc_pkg::DOC_W-1:0]           doc_b,
  input  logic signed [mkdc_pkg::VAL_W-1:0]    sort_value,
  input  logic signed [mkdc_pkg::VAL_W-1:0]    score_a,
  input  logic signed [mkdc_pkg::VAL_W-1:0]    score_b,
  output logic                                 done,
  output logic                                 a_first
);
  import mkdc_pkg::*;

  localparam int DEPTH = MAX_KEYS * DOC_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(DOC_COUNT);
  localparam int KCW   = KCNT_W + 1;

  // Held item.
  logic                    mode_r;
  logic [KEY_IDX_W-1:0]    key_r;
  logic [DOC_W-1:0]        doc_a_r;
  logic [DOC_W-1:0]        doc_b_r;
  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] score_a_r;
  logic signed [VAL_W-1:0] score_b_r;

  // Configuration registers.
  logic [KCNT_W-1:0]  key_count;
  logic [RMASK_W-1:0] reverse_mask;

  // Slot reduction results and walk state.
  logic [SW-1:0]     slot_a_calc;
  logic [SW-1:0]     slot_b_calc;
  logic [SW-1:0]     slot_a;
  logic [SW-1:0]     slot_b;
  logic [AW-1:0]     base_a;
  logic [AW-1:0]     base_b;
  logic [KCNT_W-1:0] kidx;
  logic [KCNT_W-1:0] n_eff;

  // Sort table and its registered read data.
  logic [VAL_W-1:0] sort_table [DEPTH];
  logic [VAL_W-1:0] rd_a;
  logic [VAL_W-1:0] rd_b;

  logic [AW-1:0] wr_addr;
  logic          wr_legal;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic          rev_bit;
  logic          key_answer;
  logic          tie_answer;

  // Capture an accepted item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r    <= mode;
      key_r     <= key_index;
      doc_a_r   <= doc_a;
      doc_b_r   <= doc_b;
      val_r     <= sort_value;
      score_a_r <= score_a;
      score_b_r <= score_b;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count    <= '0;
      reverse_mask <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_COUNT:    key_count    <= cfg_data[KCNT_W-1:0];
        CFG_REVERSE_MASK: reverse_mask <= cfg_data[RMASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Document numbers wrap modulo DOC_COUNT. Below 1024 documents: a registered
  // reciprocal multiply, a multiply back, a subtract and a conditional fix-up.
  generate
    if (DOC_COUNT >= (1 << DOC_W)) begin : g_no_wrap
      assign slot_a_calc = SW'(doc_a_r);
      assign slot_b_calc = SW'(doc_b_r);
    end else begin : g_wrap
      localparam int RSH   = 2 * DOC_W;
      localparam int RW    = RSH + DOC_W;
      localparam int RMULT = ((1 << RSH) + DOC_COUNT - 1) / DOC_COUNT;
      localparam int QW    = DOC_W + 1;

      logic [RW-1:0] prod_a;
      logic [RW-1:0] prod_b;
      logic [QW-1:0] qd_a;
      logic [QW-1:0] qd_b;
      logic [QW-1:0] rem_a;
      logic [QW-1:0] rem_b;

      always_ff @(posedge clk) begin
        if (cmd.reduce) begin
          prod_a <= RW'(doc_a_r) * RW'(RMULT);
          prod_b <= RW'(doc_b_r) * RW'(RMULT);
        end
      end

      always_comb begin
        qd_a  = QW'(prod_a[RW-1 -: DOC_W]) * QW'(DOC_COUNT);
        qd_b  = QW'(prod_b[RW-1 -: DOC_W]) * QW'(DOC_COUNT);
        rem_a = {1'b0, doc_a_r} - qd_a;
        rem_b = {1'b0, doc_b_r} - qd_b;
        if (rem_a >= QW'(DOC_COUNT)) begin
          rem_a = rem_a - QW'(DOC_COUNT);
        end
        if (rem_b >= QW'(DOC_COUNT)) begin
          rem_b = rem_b - QW'(DOC_COUNT);
        end
        slot_a_calc = SW'(rem_a);
        slot_b_calc = SW'(rem_b);
      end
    end
  endgenerate

  // Effective key count and walk bookkeeping.
  always_comb begin
    if ({1'b0, key_count} > KCW'(MAX_KEYS)) begin
      n_eff = KCNT_W'(MAX_KEYS);
    end else begin
      n_eff = key_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      slot_a <= slot_a_calc;
      slot_b <= slot_b_calc;
    end
    if (cmd.first) begin
      base_a <= AW'(slot_a) + AW'(DOC_COUNT);
      base_b <= AW'(slot_b) + AW'(DOC_COUNT);
      kidx   <= '0;
    end else if (cmd.step) begin
      base_a <= base_a + AW'(DOC_COUNT);
      base_b <= base_b + AW'(DOC_COUNT);
      kidx   <= kidx + KCNT_W'(1);
    end
  end

  // Table write of a load; loads to a missing key are dropped.
  assign wr_legal = ({2'b00, key_r} < KCW'(MAX_KEYS));
  assign wr_addr  = AW'(key_r) * AW'(DOC_COUNT) + AW'(slot_a);

  always_ff @(posedge clk) begin
    if (cmd.store && wr_legal) begin
      sort_table[wr_addr] <= val_r;
    end
  end

  // Two table reads per key, data registered.
  assign rd_addr_a = cmd.first ? AW'(slot_a) : base_a;
  assign rd_addr_b = cmd.first ? AW'(slot_b) : base_b;

  always_ff @(posedge clk) begin
    if (cmd.first || cmd.step) begin
      rd_a <= sort_table[rd_addr_a];
      rd_b <= sort_table[rd_addr_b];
    end
  end

  // Key answer: a after b in value, flipped by the key's reverse bit.
  assign rev_bit    = ~kidx[KCNT_W-1] & reverse_mask[kidx[KCNT_W-2:0]];
  assign key_answer = ($signed(rd_b) < $signed(rd_a)) ^ rev_bit;

  // Tie-break on score, then on the raw document numbers.
  assign tie_answer = (score_a_r != score_b_r) ? (score_a_r < score_b_r)
                                               : (doc_a_r < doc_b_r);

  // Status toward the controller.
  always_comb begin
    stat.is_compare  = (mode_r == MODE_COMPARE);
    stat.no_keys     = (n_eff == '0);
    stat.key_differs = (rd_a != rd_b);
    stat.last_key    = (({1'b0, kidx} + KCW'(1)) == {1'b0, n_eff});
  end

  // Result register: one-cycle strobe with its answer.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_key | cmd.emit_tie;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_key) begin
      a_first <= key_answer;
    end else if (cmd.emit_tie) begin
      a_first <= tie_answer;
    end
  end

endmodule

FILE: rtl/mkdc_checker.sv
// ----------------------------------------------------------------------------
// mkdc_checker
// Port-level checks of the comparator's item and result timing.
// ----------------------------------------------------------------------------
`include "multi_key_doc_comparator_unit_assert.svh"

module mkdc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic mode,
  input logic done
);
  import mkdc_pkg::*;

  logic accept;

  assign accept = start && !busy;

  // An accepted item keeps the block busy in the next cycle.
  `MKDC_ASSERT_NEXT(a_accept_busy, accept, busy)

  // A result only ends work that was in progress.
  `MKDC_ASSERT_SAME(a_done_after_busy, done, $past(busy))

  // Results are single-cycle strobes.
  `MKDC_ASSERT_NEXT(a_done_pulse, done, !done)

  // A load gives no result right after it is taken.
  `MKDC_ASSERT_NEXT(a_load_silent, accept && (mode == MODE_LOAD), !done)

endmodule

bind multi_key_doc_comparator_unit mkdc_checker u_mkdc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .mode  (mode),
  .done  (done)
);
